// ----- sv/koe_pkg.sv -----
`timescale 1ns / 1ps

package koe_pkg;

   localparam int MAX_QUBITS_DEF     = 10;
   localparam int COMPONENT_BITS_DEF = 32;
   localparam int EXP_BITS           = 48;
   localparam int CSR_ADDR_BITS      = 3;

   // request kinds
   localparam logic [1:0] REQ_WRITE_AMP = 2'd0;
   localparam logic [1:0] REQ_WRITE_OP  = 2'd1;
   localparam logic [1:0] REQ_COMPUTE   = 2'd2;
   localparam logic [1:0] REQ_UNUSED    = 2'd3;

   // result status
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_EQUAL = 2'd2;

   // product selection for the shared multiplier
   localparam logic [1:0] PICK_RE_RE = 2'd0;  // op re * amp re
   localparam logic [1:0] PICK_IM_IM = 2'd1;  // op im * amp im
   localparam logic [1:0] PICK_RE_IM = 2'd2;  // op re * amp im
   localparam logic [1:0] PICK_IM_RE = 2'd3;  // op im * amp re

   typedef struct packed {
      logic       square;
      logic [1:0] pick;
   } koe_mul_cmd_type;

endpackage

// ----- sv/koe_ram.sv -----
`timescale 1ns / 1ps

module koe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/koe_alu.sv -----
`timescale 1ns / 1ps

module koe_alu (
   input  logic                   clock,
   input  koe_pkg::koe_mul_cmd_type cmd,
   input  logic signed [31:0]     op_re,
   input  logic signed [31:0]     op_im,
   input  logic signed [31:0]     amp_re,
   input  logic signed [31:0]     amp_im,
   input  logic [31:0]            mag,
   output logic signed [65:0]     prod
);
   import koe_pkg::*;

   logic signed [32:0] opa;
   logic signed [32:0] opb;
   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;

   // one shared 33x33 signed multiplier, registered
   always_comb begin
      if (cmd.square) begin
         opa = $signed({1'b0, mag});
         opb = $signed({1'b0, mag});
      end else begin
         case (cmd.pick)
            PICK_RE_RE: begin
               opa = 33'(op_re);
               opb = 33'(amp_re);
            end
            PICK_IM_IM: begin
               opa = 33'(op_im);
               opb = 33'(amp_im);
            end
            PICK_RE_IM: begin
               opa = 33'(op_re);
               opb = 33'(amp_im);
            end
            default: begin
               opa = 33'(op_im);
               opb = 33'(amp_re);
            end
         endcase
      end
      prod_in = opa * opb;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- sv/kraus_operator_expectation_top.sv -----
`timescale 1ns / 1ps

// Kraus operator expectation engine. Amplitudes (req_tuser 0) and operator entries
// (req_tuser 1, row-major 0..15) are loaded one transaction per cycle while the block
// is idle. A compute transaction (req_tuser 2) walks every amplitude group
// whose index has the target bits clear, multiplies the 2x2 or 4x4 operator into it
// and sums the squared magnitudes into a saturating Q4.44 total, returned on the rsp
// side with a status. All products are formed one at a time by one shared 33x33
// multiplier, fed through the single amplitude read port; a walk covers 2^(n-1) groups
// of dimension 2 for one qubit, or 2^(n-2) groups of dimension 4 for two. Saturation
// ends the walk early. A bad qubit selection gives a result in the cycle after
// acceptance. The input side is not ready while a compute is in progress or its
// result waits on the rsp side. Never-written store entries read as undefined.
module kraus_operator_expectation_top #(
   parameter int MAX_QUBITS     = koe_pkg::MAX_QUBITS_DEF,
   parameter int COMPONENT_BITS = koe_pkg::COMPONENT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // address[9:0], value_re[41:10], value_im[73:42], qubit_a[77:74],
   // qubit_b[81:78], two_qubit[82], zero fill
   input  logic [87:0]                      req_tdata,
   // req_type[1:0]
   input  logic [1:0]                       req_tuser,
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // expectation[47:0]
   output logic [47:0]                      rsp_tdata,
   // status[1:0]
   output logic [1:0]                       rsp_tuser,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [koe_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import koe_pkg::*;

   localparam int MQ     = MAX_QUBITS;
   localparam int CB     = COMPONENT_BITS;
   localparam int NBITS  = 5;
   localparam logic [47:0] EXP_MAX = '1;

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD   = 4'd1;
   localparam logic [3:0] S_M0   = 4'd2;
   localparam logic [3:0] S_M1   = 4'd3;
   localparam logic [3:0] S_M2   = 4'd4;
   localparam logic [3:0] S_M3   = 4'd5;
   localparam logic [3:0] S_M4   = 4'd6;
   localparam logic [3:0] S_C0   = 4'd7;
   localparam logic [3:0] S_C1   = 4'd8;
   localparam logic [3:0] S_C2   = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   // request fields
   logic [9:0]  f_address;
   logic [31:0] f_value_re;
   logic [31:0] f_value_im;
   logic [3:0]  f_qubit_a;
   logic [3:0]  f_qubit_b;
   logic        f_two_qubit;

   assign f_address   = req_tdata[9:0];
   assign f_value_re  = req_tdata[41:10];
   assign f_value_im  = req_tdata[73:42];
   assign f_qubit_a   = req_tdata[77:74];
   assign f_qubit_b   = req_tdata[81:78];
   assign f_two_qubit = req_tdata[82];

   logic [3:0]        state_ff, state_in;
   logic [MQ-1:0]     grp_ff, grp_in;
   logic [1:0]        row_ff, row_in;
   logic [1:0]        col_ff, col_in;
   logic [3:0]        qa_ff, qa_in;
   logic [3:0]        qb_ff, qb_in;
   logic              two_ff, two_in;
   logic signed [63:0] sr_ff, sr_in;
   logic signed [63:0] si_ff, si_in;
   logic [47:0]       acc_ff, acc_in;
   logic [1:0]        status_ff, status_in;
   logic [3:0]        qubits_ff;

   // register port
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {28'd0, qubits_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         qubits_ff <= 4'd1;
      end else if (csr_wr && !csr_paddr[2]) begin
         qubits_ff <= csr_pwdata[3:0];
      end
   end

   // effective qubit count, clamped to the store size
   logic [NBITS-1:0] n_eff;
   assign n_eff = (NBITS'(qubits_ff) > NBITS'(MQ)) ? NBITS'(MQ) : NBITS'(qubits_ff);

   logic req_acc;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // stores
   logic [2*CB-1:0] amp_rd, op_rd;
   logic [MQ-1:0]   amp_rd_addr;
   logic [3:0]      op_rd_addr;
   logic            amp_we, op_we;
   logic [2*CB-1:0] wr_word;

   assign wr_word = {f_value_im[31 -: CB], f_value_re[31 -: CB]};
   assign amp_we  = req_acc && (req_tuser == REQ_WRITE_AMP);
   assign op_we   = req_acc && (req_tuser == REQ_WRITE_OP) && (f_address[9:4] == 6'd0);

   koe_ram #(.WIDTH(2 * CB), .DEPTH(1 << MQ)) u_amp_ram (
      .clock   (clock),
      .wr_en   (amp_we),
      .wr_addr (MQ'(f_address)),
      .wr_data (wr_word),
      .rd_addr (amp_rd_addr),
      .rd_data (amp_rd)
   );

   koe_ram #(.WIDTH(2 * CB), .DEPTH(16)) u_op_ram (
      .clock   (clock),
      .wr_en   (op_we),
      .wr_addr (f_address[3:0]),
      .wr_data (wr_word),
      .rd_addr (op_rd_addr),
      .rd_data (op_rd)
   );

   // stored components back to Q1.30 with the dropped low bits cleared
   logic signed [31:0] amp_re, amp_im, op_re, op_im;
   assign amp_re = $signed(32'(amp_rd[CB-1:0]) << (32 - CB));
   assign amp_im = $signed(32'(amp_rd[2*CB-1:CB]) << (32 - CB));
   assign op_re  = $signed(32'(op_rd[CB-1:0]) << (32 - CB));
   assign op_im  = $signed(32'(op_rd[2*CB-1:CB]) << (32 - CB));

   // group base index: group counter with zeros inserted at the target bits
   logic [3:0]    lo_q, hi_q;
   logic [MQ-1:0] mask_lo, mask_hi, ins1, ins2, base_idx, bit_a, bit_b;

   always_comb begin
      lo_q     = (two_ff && (qb_ff < qa_ff)) ? qb_ff : qa_ff;
      hi_q     = (qb_ff < qa_ff) ? qa_ff : qb_ff;
      mask_lo  = ~({MQ{1'b1}} << lo_q);
      ins1     = ((grp_ff & ~mask_lo) << 1) | (grp_ff & mask_lo);
      mask_hi  = ~({MQ{1'b1}} << hi_q);
      ins2     = ((ins1 & ~mask_hi) << 1) | (ins1 & mask_hi);
      base_idx = two_ff ? ins2 : ins1;
      bit_a    = MQ'(1) << qa_ff;
      bit_b    = MQ'(1) << qb_ff;
      amp_rd_addr = base_idx | (col_ff[0] ? bit_a : '0)
                             | ((two_ff && col_ff[1]) ? bit_b : '0);
      op_rd_addr  = two_ff ? {row_ff, col_ff} : {2'b00, row_ff[0], col_ff[0]};
   end

   // last group of the walk
   logic [NBITS-1:0] grp_exp;
   logic [MQ-1:0]    grp_mask;
   logic             grp_last, col_last, row_last;
   assign grp_exp  = two_ff ? (n_eff - NBITS'(2)) : (n_eff - NBITS'(1));
   assign grp_mask = ~({MQ{1'b1}} << grp_exp);
   assign grp_last = (grp_ff == grp_mask);
   assign col_last = two_ff ? (col_ff == 2'd3) : (col_ff == 2'd1);
   assign row_last = two_ff ? (row_ff == 2'd3) : (row_ff == 2'd1);

   // row component to Q.30 and its magnitude
   logic signed [63:0] comp_sel, comp_c;
   logic [63:0]        comp_abs;
   logic               comp_ovf;
   always_comb begin
      comp_sel = (state_ff == S_C0) ? sr_ff : si_ff;
      comp_c   = comp_sel >>> 26;
      comp_abs = comp_c[63] ? 64'(-comp_c) : 64'(comp_c);
      comp_ovf = |comp_abs[63:32];
   end

   // shared multiplier
   koe_mul_cmd_type mul_cmd;
   logic signed [65:0] prod;
   logic signed [63:0] prod4;

   always_comb begin
      mul_cmd.square = (state_ff == S_C0) || (state_ff == S_C1);
      case (state_ff)
         S_M0:    mul_cmd.pick = PICK_RE_RE;
         S_M1:    mul_cmd.pick = PICK_IM_IM;
         S_M2:    mul_cmd.pick = PICK_RE_IM;
         default: mul_cmd.pick = PICK_IM_RE;
      endcase
   end

   koe_alu u_alu (
      .clock  (clock),
      .cmd    (mul_cmd),
      .op_re  (op_re),
      .op_im  (op_im),
      .amp_re (amp_re),
      .amp_im (amp_im),
      .mag    (comp_abs[31:0]),
      .prod   (prod)
   );

   // Q2.60 product floored to Q.56
   assign prod4 = 64'(prod >>> 4);

   // saturating accumulate of a squared magnitude, floored to Q.44
   logic [48:0] acc_sum;
   logic        acc_sat;
   assign acc_sum = {1'b0, acc_ff} + {1'b0, prod[63:16]};
   assign acc_sat = acc_sum[48];

   // request checks
   logic [1:0] chk_status;
   always_comb begin
      if ((NBITS'(f_qubit_a) >= n_eff) || (f_two_qubit && (NBITS'(f_qubit_b) >= n_eff))) begin
         chk_status = STATUS_RANGE;
      end else if (f_two_qubit && ((f_qubit_a == f_qubit_b) || (n_eff < NBITS'(2)))) begin
         chk_status = STATUS_EQUAL;
      end else begin
         chk_status = STATUS_OK;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      grp_in    = grp_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      qa_in     = qa_ff;
      qb_in     = qb_ff;
      two_in    = two_ff;
      sr_in     = sr_ff;
      si_in     = si_ff;
      acc_in    = acc_ff;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_tuser == REQ_COMPUTE)) begin
               qa_in     = f_qubit_a;
               qb_in     = f_qubit_b;
               two_in    = f_two_qubit;
               grp_in    = '0;
               row_in    = 2'd0;
               col_in    = 2'd0;
               acc_in    = '0;
               status_in = chk_status;
               state_in  = (chk_status == STATUS_OK) ? S_RD : S_OUT;
            end
         end
         S_RD: state_in = S_M0;
         S_M0: state_in = S_M1;
         S_M1: begin
            sr_in    = ((col_ff == 2'd0) ? 64'sd0 : sr_ff) + prod4;
            state_in = S_M2;
         end
         S_M2: begin
            sr_in    = sr_ff - prod4;
            state_in = S_M3;
         end
         S_M3: begin
            si_in    = ((col_ff == 2'd0) ? 64'sd0 : si_ff) + prod4;
            state_in = S_M4;
         end
         S_M4: begin
            si_in = si_ff + prod4;
            if (col_last) begin
               state_in = S_C0;
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = S_RD;
            end
         end
         S_C0: begin
            // real part squared goes into the multiplier
            if (comp_ovf) begin
               acc_in   = EXP_MAX;
               state_in = S_OUT;
            end else begin
               state_in = S_C1;
            end
         end
         S_C1: begin
            if (acc_sat || comp_ovf) begin
               acc_in   = EXP_MAX;
               state_in = S_OUT;
            end else begin
               acc_in   = acc_sum[47:0];
               state_in = S_C2;
            end
         end
         S_C2: begin
            col_in = 2'd0;
            if (acc_sat) begin
               acc_in   = EXP_MAX;
               state_in = S_OUT;
            end else begin
               acc_in = acc_sum[47:0];
               if (!row_last) begin
                  row_in   = row_ff + 2'd1;
                  state_in = S_RD;
               end else if (grp_last) begin
                  state_in = S_OUT;
               end else begin
                  row_in   = 2'd0;
                  grp_in   = grp_ff + MQ'(1);
                  state_in = S_RD;
               end
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      grp_ff    <= grp_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      qa_ff     <= qa_in;
      qb_ff     <= qb_in;
      two_ff    <= two_in;
      sr_ff     <= sr_in;
      si_ff     <= si_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
   end

   // result holds in the accumulator until taken
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = acc_ff;
   assign rsp_tuser  = status_ff;

endmodule

// ----- sv/koe_checker.sv -----
`timescale 1ns / 1ps

module koe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import koe_pkg::*;

   // a waiting result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result dropped or changed while stalled");

   // no new transaction is taken while a result waits
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("input ready while result pending");

   // an error status carries a zero expectation
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> (rsp_tdata == 48'd0))
      else $error("error status with nonzero expectation");

   // store writes and unused-kind requests never cause a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != REQ_COMPUTE) |=> !rsp_tvalid)
      else $error("result after a store write");

   // after reset no result is shown
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind kraus_operator_expectation_top koe_checker u_koe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// result record held by the scoreboard
typedef struct {
   logic [47:0] expectation;
   logic [1:0]  status;
} koe_result_type;

// keeps its own copy of both stores and the qubit count and predicts each compute
class expectation_scoreboard;
   int             amp_re [1024];
   int             amp_im [1024];
   int             op_re [16];
   int             op_im [16];
   int unsigned    qubits;
   koe_result_type pending [$];
   int             mismatches;

   function new();
      qubits = 1;
      mismatches = 0;
   endfunction

   // adds one squared row component to the total, returns 0 on saturation
   function bit add_square(longint sum56, ref logic [47:0] total);
      longint      c;
      logic [63:0] m;
      logic [63:0] sq;
      c = sum56 >>> 26;
      m = (c < 0) ? -c : c;
      if (m >= 64'h1_0000_0000)
         return 1'b0;
      sq = (m * m) >> 16;
      if (sq > 64'(48'hFFFF_FFFF_FFFF - total))
         return 1'b0;
      total = total + sq[47:0];
      return 1'b1;
   endfunction

   function bit apply_group(int unsigned idx [4], int dim, ref logic [47:0] total);
      longint sr, si, ar, ai, orr, oi;
      for (int r = 0; r < dim; r++) begin
         sr = 0;
         si = 0;
         for (int k = 0; k < dim; k++) begin
            orr = op_re[r*dim+k];
            oi  = op_im[r*dim+k];
            ar  = amp_re[idx[k]];
            ai  = amp_im[idx[k]];
            sr += ((orr * ar) >>> 4) - ((oi * ai) >>> 4);
            si += ((orr * ai) >>> 4) + ((oi * ar) >>> 4);
         end
         if (!add_square(sr, total) || !add_square(si, total))
            return 1'b0;
      end
      return 1'b1;
   endfunction

   static function int unsigned gap_bit(int unsigned v, int pos);
      int unsigned low;
      low = v & ((1 << pos) - 1);
      return ((v ^ low) << 1) | low;
   endfunction

   // accepted request transaction
   function void note_request(logic [1:0] kind, logic [9:0] addr, logic [31:0] re,
                              logic [31:0] im, logic [3:0] qa, logic [3:0] qb, logic two);
      koe_result_type res;
      int unsigned n, groups, lo, hi;
      int unsigned idx [4];
      if (kind == koe_pkg::REQ_WRITE_AMP) begin
         amp_re[addr] = re;
         amp_im[addr] = im;
         return;
      end
      if (kind == koe_pkg::REQ_WRITE_OP) begin
         if (addr < 16) begin
            op_re[addr] = re;
            op_im[addr] = im;
         end
         return;
      end
      if (kind != koe_pkg::REQ_COMPUTE)
         return;
      n = (qubits > 10) ? 10 : qubits;
      res.expectation = '0;
      res.status = koe_pkg::STATUS_OK;
      if (qa >= n || (two && qb >= n))
         res.status = koe_pkg::STATUS_RANGE;
      else if (two && (qa == qb || n < 2))
         res.status = koe_pkg::STATUS_EQUAL;
      if (res.status == koe_pkg::STATUS_OK && !two) begin
         groups = 1 << (n - 1);
         for (int unsigned i = 0; i < groups; i++) begin
            idx[0] = gap_bit(i, qa);
            idx[1] = idx[0] | (1 << qa);
            if (!apply_group(idx, 2, res.expectation)) begin
               res.expectation = '1;
               break;
            end
         end
      end else if (res.status == koe_pkg::STATUS_OK) begin
         lo = (qa < qb) ? qa : qb;
         hi = (qa < qb) ? qb : qa;
         groups = 1 << (n - 2);
         for (int unsigned i = 0; i < groups; i++) begin
            idx[0] = gap_bit(gap_bit(i, lo), hi);
            idx[1] = idx[0] | (1 << qa);
            idx[2] = idx[0] | (1 << qb);
            idx[3] = idx[0] | (1 << qa) | (1 << qb);
            if (!apply_group(idx, 4, res.expectation)) begin
               res.expectation = '1;
               break;
            end
         end
      end
      pending = {pending, res};
   endfunction

   // accepted response transaction
   function void check_result(logic [47:0] expectation, logic [1:0] status);
      koe_result_type want;
      if (pending.size() == 0) begin
         $error("response with nothing expected: expectation %h status %0d",
                expectation, status);
         mismatches++;
         return;
      end
      want = pending.pop_front();
      if (expectation !== want.expectation) begin
         $error("expectation: expected %h, got %h", want.expectation, expectation);
         mismatches++;
      end
      if (status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, status);
         mismatches++;
      end
   endfunction
endclass

module tb_top;
   import koe_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;     // address, value_re, value_im, qubit_a, qubit_b, two_qubit
   logic [1:0]  req_tuser;     // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;     // expectation
   logic [1:0]  rsp_tuser;     // status
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   expectation_scoreboard board = new();

   int unsigned cycles = 0;
   int          send_idle_pct = 0;   // chance of a gap before a request transaction
   int          rsp_stall_pct = 0;   // chance of holding rsp_tready low

   kraus_operator_expectation_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // response side: check each accepted transaction, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // one register write: setup cycle then access cycle
   task automatic write_qubits(input logic [3:0] n);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= '0;
      csr_pwdata  <= 32'(n);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.qubits = n;
   endtask

   // one request transaction, with an optional gap in front; called at a clock edge
   task automatic send_request(input int unsigned kind, input int unsigned addr,
                               input int unsigned re, input int unsigned im,
                               input int unsigned qa, input int unsigned qb,
                               input int unsigned two);
      logic [1:0]  k;
      logic [9:0]  a;
      logic [31:0] vr, vi;
      logic [3:0]  ta, tq;
      logic        t2;
      k  = 2'(kind);
      a  = 10'(addr);
      vr = re;
      vi = im;
      ta = 4'(qa);
      tq = 4'(qb);
      t2 = two[0];
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {5'b0, t2, tq, ta, vi, vr, a};
      do @(posedge clock); while (!req_tready);
      board.note_request(k, a, vr, vi, ta, tq, t2);
      // leave valid high; the next call or the drain lowers it
   endtask

   task automatic drop_valid();
      req_tvalid <= 1'b0;
   endtask

   // full-scale or scaled-down Q1.30 component
   function automatic logic [31:0] pick_component();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom) >>> $urandom_range(2, 12));
      endcase
   endfunction

   // wait until every expected response has come, then let the block settle
   task automatic drain();
      drop_valid();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // mostly store writes, plus mostly valid computes with random content and noise
   task automatic random_traffic(input int count, input int max_computes);
      int          computes;
      int unsigned n;
      int unsigned qa, qb, two;
      computes = 0;
      n = (board.qubits > 10) ? 10 : board.qubits;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7:
               send_request(REQ_WRITE_AMP, $urandom, pick_component(), pick_component(),
                            $urandom, $urandom, $urandom);
            8, 9, 10, 11:
               send_request(REQ_WRITE_OP, $urandom_range(9) ? $urandom_range(15) : $urandom,
                            pick_component(), pick_component(), $urandom, $urandom, $urandom);
            12:
               send_request(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom);
            default: begin
               if (computes < max_computes) begin
                  computes++;
                  two = $urandom_range(1);
                  if ($urandom_range(4) == 0 || n == 0) begin
                     qa = $urandom_range(15);
                     qb = $urandom_range(15);
                  end else begin
                     qa = $urandom_range(n - 1);
                     qb = $urandom_range(n - 1);
                  end
                  send_request(REQ_COMPUTE, $urandom, $urandom, $urandom, qa, qb, two);
               end
            end
         endcase
      end
   endtask

   initial begin
      logic [3:0] settings [8] = '{4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd10, 4'd15, 4'd5};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // fill both stores so that no compute ever touches an unwritten entry
      for (int a = 0; a < 16; a++)
         send_request(REQ_WRITE_OP, a, pick_component(), pick_component(), 0, 0, 0);
      for (int a = 0; a < 1024; a++)
         send_request(REQ_WRITE_AMP, a, pick_component(), pick_component(), 0, 0, 0);
      drain();

      // directed: field extremes, every request kind, the error cases
      write_qubits(4'd1);
      send_request(REQ_WRITE_AMP, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 4'hF, 4'hF, 1'b1);
      send_request(REQ_WRITE_AMP, 10'd1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
      send_request(REQ_WRITE_OP, 10'd0, 32'h4000_0000, 32'h0, 0, 0, 0);
      send_request(REQ_WRITE_OP, 10'd3, 32'hC000_0000, 32'h0, 0, 0, 0);
      send_request(REQ_WRITE_OP, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
      send_request(REQ_WRITE_OP, 10'd16, 32'h1234_5678, 32'h0, 0, 0, 0);
      send_request(REQ_COMPUTE, 10'd0, 0, 0, 4'd0, 4'd0, 1'b0);   // plain single qubit
      send_request(REQ_COMPUTE, 10'd0, 0, 0, 4'd1, 4'd0, 1'b0);   // qubit out of range
      send_request(REQ_COMPUTE, 10'd0, 0, 0, 4'd0, 4'd0, 1'b1);   // two qubits, n too small
      send_request(REQ_COMPUTE, 10'd0, 0, 0, 4'd0, 4'd15, 1'b1);  // second qubit out of range
      send_request(REQ_UNUSED, 10'd1023, '1, '1, 4'hF, 4'hF, 1'b1); // unused kind
      send_request(REQ_WRITE_AMP, 10'd1, 32'h0100_0000, 32'hFF00_0000, 0, 0, 0);
      send_request(REQ_COMPUTE, 10'd0, 0, 0, 4'd0, 4'd0, 1'b0);
      drain();
      write_qubits(4'd2);
      send_request(REQ_COMPUTE, 10'd0, 0, 0, 4'd1, 4'd1, 1'b1);   // equal qubits
      send_request(REQ_COMPUTE, 10'd0, 0, 0, 4'd1, 4'd0, 1'b1);   // swapped column order
      send_request(REQ_COMPUTE, 10'd0, 0, 0, 4'd0, 4'd1, 1'b1);
      drain();
      write_qubits(4'd0);
      send_request(REQ_COMPUTE, 10'd0, 0, 0, 4'd0, 4'd0, 1'b0);   // register zero
      drain();

      // random phases across register settings and handshake pressure
      for (int p = 0; p < 16; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 47; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 47; end
            default: begin send_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         write_qubits(settings[p % 8]);
         // large vectors make each compute slow, so keep them rare there
         random_traffic(6, (settings[p % 8] >= 8) ? 3 : 40);
         drain();
      end

      if (board.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

// ----- sim.f -----
sv/koe_pkg.sv
sv/koe_ram.sv
sv/koe_alu.sv
sv/kraus_operator_expectation_top.sv
sv/koe_checker.sv
tb/tb_top.sv
